@@ hw/rtl/kfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared types and constants for the KISS frame decoder.
// ----------------------------------------------------------------------------
package kfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 12;

  localparam logic [ByteW-1:0] Fend  = 8'hC0;
  localparam logic [ByteW-1:0] Fesc  = 8'hDB;
  localparam logic [ByteW-1:0] Tfend = 8'hDC;
  localparam logic [ByteW-1:0] Tfesc = 8'hDD;

  localparam logic [CountW-1:0] MaxLenReset = 12'd256;
  localparam logic [CountW-1:0] OpenCount   = 12'd2;

  typedef enum logic [1:0] {
    ModeHunt   = 2'd0,
    ModeOpen   = 2'd1,
    ModeData   = 2'd2,
    ModeEscape = 2'd3
  } rx_mode_e;

  typedef enum logic {
    KindData = 1'b0,
    KindEnd  = 1'b1
  } kind_e;

  // one decoded result, with a flag telling whether the byte produced one
  typedef struct packed {
    logic             emit;
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             is_command;
    logic             status;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/kfd_in_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfd_in_reg
// Input register: holds one raw byte until the decode stage consumes it.
// ----------------------------------------------------------------------------
module kfd_in_reg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [kfd_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                     advance_i,
  output logic                          valid_o,
  output logic [kfd_pkg::ByteW-1:0]     byte_o
);

  logic                      valid_d, valid_q;
  logic [kfd_pkg::ByteW-1:0] byte_q;
  logic                      take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule
`default_nettype wire

@@ hw/rtl/kfd_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfd_decode
// Frame state (mode, raw length, command flag) and the per-byte unescape.
// ----------------------------------------------------------------------------
module kfd_decode (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [kfd_pkg::ByteW-1:0]  byte_i,
  input  wire logic [kfd_pkg::CountW-1:0] max_len_i,
  output kfd_pkg::result_t               result_o
);

  kfd_pkg::rx_mode_e          mode_d, mode_q;
  logic [kfd_pkg::CountW-1:0] count_d, count_q;
  logic                       first_d, first_q;
  logic [kfd_pkg::CountW-1:0] count_inc;
  logic [kfd_pkg::ByteW-1:0]  unesc;
  kfd_pkg::result_t           res;

  assign count_inc = (count_q == {kfd_pkg::CountW{1'b1}}) ? count_q
                                                          : count_q + kfd_pkg::CountW'(1);

  always_comb begin
    if (byte_i == kfd_pkg::Tfend) begin
      unesc = kfd_pkg::Fend;
    end else if (byte_i == kfd_pkg::Tfesc) begin
      unesc = kfd_pkg::Fesc;
    end else begin
      unesc = byte_i;
    end
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    first_d = first_q;
    unique case (mode_q)
      kfd_pkg::ModeHunt: begin
        if (byte_i == kfd_pkg::Fend) mode_d = kfd_pkg::ModeOpen;
      end
      kfd_pkg::ModeOpen: begin
        if (byte_i != kfd_pkg::Fend) begin
          count_d = kfd_pkg::OpenCount;
          if (byte_i == kfd_pkg::Fesc) begin
            mode_d  = kfd_pkg::ModeEscape;
            first_d = 1'b1;
          end else begin
            mode_d  = kfd_pkg::ModeData;
            first_d = 1'b0;
          end
        end
      end
      kfd_pkg::ModeData, kfd_pkg::ModeEscape: begin
        if (byte_i == kfd_pkg::Fend) begin
          mode_d  = kfd_pkg::ModeHunt;
          count_d = '0;
          first_d = 1'b1;
        end else if (mode_q == kfd_pkg::ModeData && byte_i == kfd_pkg::Fesc) begin
          mode_d  = kfd_pkg::ModeEscape;
          count_d = count_inc;
        end else begin
          mode_d  = kfd_pkg::ModeData;
          count_d = count_inc;
          first_d = 1'b0;
        end
      end
      default: mode_d = kfd_pkg::ModeHunt;
    endcase
  end

  // result
  always_comb begin
    res            = '0;
    res.kind       = kfd_pkg::KindData;
    res.data       = (mode_q == kfd_pkg::ModeEscape) ? unesc : byte_i;
    res.is_command = first_q;
    unique case (mode_q)
      kfd_pkg::ModeHunt: res.emit = 1'b0;
      kfd_pkg::ModeOpen: begin
        res.emit       = (byte_i != kfd_pkg::Fend) && (byte_i != kfd_pkg::Fesc);
        res.is_command = 1'b1;
      end
      kfd_pkg::ModeData, kfd_pkg::ModeEscape: begin
        if (byte_i == kfd_pkg::Fend) begin
          // closing delimiter, a dangling escape is simply dropped
          res.emit       = 1'b1;
          res.kind       = kfd_pkg::KindEnd;
          res.data       = '0;
          res.is_command = 1'b0;
          res.status     = (count_inc > max_len_i);
        end else begin
          res.emit = !(mode_q == kfd_pkg::ModeData && byte_i == kfd_pkg::Fesc);
        end
      end
      default: res.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= kfd_pkg::ModeHunt;
      count_q <= '0;
      first_q <= 1'b1;
    end else if (step_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      first_q <= first_d;
    end
  end

  assign result_o = res;

endmodule
`default_nettype wire

@@ hw/rtl/kfd_out_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfd_out_reg
// Result register: holds one decoded result until the sink takes it.
// ----------------------------------------------------------------------------
module kfd_out_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire kfd_pkg::result_t      result_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output kfd_pkg::result_t           result_o
);

  logic             valid_d, valid_q;
  kfd_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule
`default_nettype wire

@@ hw/rtl/kiss_frame_decoder_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kiss_frame_decoder_top
// KISS receive-side frame decoder, one raw byte per transaction.
// ----------------------------------------------------------------------------
// Raw link bytes enter an input register, are decoded combinationally against
// the frame state, and any result lands in a result register; one byte per
// cycle is sustained, each byte passing both registers in turn. Throughput drops
// only while the result register is full and the sink holds out_ready_i low
// and the pending byte produces a result. Each result is a decoded payload
// byte (is_command marks the first of a frame) or an end marker whose status
// flags a raw frame length, both delimiters counted, above max_frame_len.
// Write max_frame_len only while the decoder is idle.
module kiss_frame_decoder_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [kfd_pkg::CountW-1:0] cfg_max_frame_len_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [kfd_pkg::ByteW-1:0]  in_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           kind_o,
  output logic [kfd_pkg::ByteW-1:0]      out_byte_o,
  output logic                           is_command_o,
  output logic                           status_o
);

  logic [kfd_pkg::CountW-1:0] max_len_q;
  logic                       s1_valid;
  logic [kfd_pkg::ByteW-1:0]  s1_byte;
  logic                       s1_step;
  logic                       out_free;
  kfd_pkg::result_t           dec_res;
  kfd_pkg::result_t           out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= kfd_pkg::MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_max_frame_len_i;
    end
  end

  // a byte without a result never waits on the sink
  assign s1_step = s1_valid && (!dec_res.emit || out_free);

  kfd_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (s1_step),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  kfd_decode u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_step),
    .byte_i    (s1_byte),
    .max_len_i (max_len_q),
    .result_o  (dec_res)
  );

  kfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_step && dec_res.emit),
    .result_i    (dec_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign kind_o       = out_res.kind;
  assign out_byte_o   = out_res.data;
  assign is_command_o = out_res.is_command;
  assign status_o     = out_res.status;

  // end marker carries no byte and no command flag
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> out_byte_o == '0 && !is_command_o)
    else $error("end marker with payload bits");

  // status only set on end markers
  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> kind_o)
    else $error("status set on payload byte");

  // input side stalls only while a byte is held and cannot move on
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid && dec_res.emit && out_valid_o && !out_ready_i)
    else $error("input stalled without cause");

endmodule
`default_nettype wire
